FILE: design/rebe_pkg.sv
// Shared types, constants and helper functions for the rotary encoder and button event unit.
// Depends on nothing; used by rebe_decide and rotary_encoder_button_events_unit.
package rebe_pkg;

    // Encoder steps per detent and width of the elapsed-tick counters.
    localparam int DETENT_STEPS     = 4;
    localparam int TICK_COUNT_WIDTH = 16;
    localparam int CFG_WIDTH        = 16;
    localparam int ADDR_WIDTH       = 3;

    // Register reset values.
    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 16'd40;
    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd600;

    // Register indexes on the configuration port.
    localparam logic REG_DEBOUNCE   = 1'b0;
    localparam logic REG_LONG_PRESS = 1'b1;

    // Result codes.
    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_CW    = 3'd1,
        EV_CCW   = 3'd2,
        EV_CLICK = 3'd3,
        EV_LONG  = 3'd4
    } t_event;

    // Complete detector state carried from one item to the next.
    typedef struct packed {
        logic [1:0]                  prev_ab;
        logic signed [3:0]           step_accum;
        logic                        button_last;
        logic                        button_stable;
        logic [TICK_COUNT_WIDTH-1:0] since_change;
        logic                        held;
        logic                        long_done;
        logic [TICK_COUNT_WIDTH-1:0] held_ticks;
    } t_state;

    localparam t_state STATE_RESET = '{
        prev_ab:       2'b00,
        step_accum:    4'sd0,
        button_last:   1'b1,
        button_stable: 1'b1,
        since_change:  '0,
        held:          1'b0,
        long_done:     1'b0,
        held_ticks:    '0
    };

    // Quadrature transition table indexed by {previous AB, current AB}.
    function automatic logic signed [1:0] quad_delta(input logic [3:0] idx);
        logic signed [1:0] d;
        case (idx) inside
            4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
            4'd1, 4'd7, 4'd8, 4'd14:  d = -2'sd1;
            default:                  d = 2'sd0;
        endcase
        return d;
    endfunction

    // Elapsed-tick increment that sticks at all ones.
    function automatic logic [TICK_COUNT_WIDTH-1:0] sat_inc(
        input logic [TICK_COUNT_WIDTH-1:0] v
    );
        logic [TICK_COUNT_WIDTH-1:0] r;
        if (v == {TICK_COUNT_WIDTH{1'b1}}) begin
            r = v;
        end else begin
            r = v + TICK_COUNT_WIDTH'(1);
        end
        return r;
    endfunction

endpackage

FILE: design/rebe_decide.sv
// Combinational next-state and event decision for one tick of the encoder and button.
// Depends on rebe_pkg for the state struct, event codes and helper functions.
module rebe_decide (
    input  rebe_pkg::t_state                   i_state,
    input  logic [1:0]                         i_ab,
    input  logic                               i_raw,
    input  logic [rebe_pkg::CFG_WIDTH-1:0]     i_debounce,
    input  logic [rebe_pkg::CFG_WIDTH-1:0]     i_long_press,
    output rebe_pkg::t_state                   o_state,
    output rebe_pkg::t_event                   o_code
);

    localparam logic signed [4:0] DETENT = 5'(rebe_pkg::DETENT_STEPS);

    logic signed [1:0] delta;
    logic signed [4:0] acc;
    logic              enc_fire;
    logic              short_fire;

    assign delta = rebe_pkg::quad_delta({i_state.prev_ab, i_ab});
    assign acc   = {i_state.step_accum[3], i_state.step_accum} + {{3{delta[1]}}, delta};

    // Encoder first; a detent event skips the button logic for this tick.
    always_comb begin
        o_state              = i_state;
        o_state.since_change = rebe_pkg::sat_inc(i_state.since_change);
        o_state.held_ticks   = rebe_pkg::sat_inc(i_state.held_ticks);
        o_code               = rebe_pkg::EV_NONE;
        enc_fire             = 1'b0;
        short_fire           = 1'b0;

        if (i_ab != i_state.prev_ab) begin
            o_state.prev_ab = i_ab;
            if (acc >= DETENT) begin
                o_state.step_accum = 4'sd0;
                o_code             = rebe_pkg::EV_CW;
                enc_fire           = 1'b1;
            end else if (acc <= -DETENT) begin
                o_state.step_accum = 4'sd0;
                o_code             = rebe_pkg::EV_CCW;
                enc_fire           = 1'b1;
            end else begin
                o_state.step_accum = acc[3:0];
            end
        end

        if (!enc_fire) begin
            // Any raw change restarts the debounce count.
            if (i_raw != i_state.button_last) begin
                o_state.button_last  = i_raw;
                o_state.since_change = '0;
            end
            // Accept a stable new level as a press or a release.
            if ((o_state.since_change >= i_debounce) && (i_raw != i_state.button_stable)) begin
                o_state.button_stable = i_raw;
                if (!i_raw) begin
                    o_state.held       = 1'b1;
                    o_state.long_done  = 1'b0;
                    o_state.held_ticks = '0;
                end else begin
                    o_state.held = 1'b0;
                    if (!i_state.long_done) begin
                        o_code     = rebe_pkg::EV_CLICK;
                        short_fire = 1'b1;
                    end
                end
            end
            // Long press fires once per hold.
            if (!short_fire && o_state.held && !o_state.long_done &&
                (o_state.held_ticks >= i_long_press)) begin
                o_state.long_done = 1'b1;
                o_code            = rebe_pkg::EV_LONG;
            end
        end
    end

endmodule

FILE: design/rotary_encoder_button_events_unit.sv
// Rotary encoder and debounced push button event unit: top level with handshakes and registers.
// An item passes the input register, then the result register, and waits there until taken.
// Throughput: one item per cycle while results are taken; a waiting result stalls the input
// register, which holds one more item before o_ready drops.
// Reset (i_rst_n low, synchronous) empties both stages, restores the detector state and
// loads debounce_ticks = 40 and long_press_ticks = 600.
module rotary_encoder_button_events_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input item channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_enc_a,
    input  logic                              i_enc_b,
    input  logic                              i_button_raw,
    // Result item channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [2:0]                        o_event_code,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rebe_pkg::ADDR_WIDTH-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic                           r_in_valid;
    logic [1:0]                     r_in_ab;
    logic                           r_in_raw;
    logic                           r_out_valid;
    rebe_pkg::t_event               r_code;
    rebe_pkg::t_state               r_state;
    rebe_pkg::t_state               n_state;
    rebe_pkg::t_event               n_code;
    logic [rebe_pkg::CFG_WIDTH-1:0] r_debounce;
    logic [rebe_pkg::CFG_WIDTH-1:0] r_long_press;
    logic                           advance;
    logic                           cfg_write;

    // Pipeline flow control.
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign o_valid = r_out_valid;
    assign o_event_code = r_code;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_ab  <= {i_enc_a, i_enc_b};
            r_in_raw <= i_button_raw;
        end
    end

    // Per-tick decision logic.
    rebe_decide u_decide (
        .i_state      (r_state),
        .i_ab         (r_in_ab),
        .i_raw        (r_in_raw),
        .i_debounce   (r_debounce),
        .i_long_press (r_long_press),
        .o_state      (n_state),
        .o_code       (n_code)
    );

    // Detector state and result register advance together.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= rebe_pkg::STATE_RESET;
        end else if (advance) begin
            r_out_valid <= 1'b1;
            r_state     <= n_state;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_code <= n_code;
        end
    end

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= rebe_pkg::DEBOUNCE_RESET;
            r_long_press <= rebe_pkg::LONG_PRESS_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                rebe_pkg::REG_DEBOUNCE:   r_debounce   <= pwdata[rebe_pkg::CFG_WIDTH-1:0];
                rebe_pkg::REG_LONG_PRESS: r_long_press <= pwdata[rebe_pkg::CFG_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        case (paddr[2])
            rebe_pkg::REG_DEBOUNCE:   prdata = {16'd0, r_debounce};
            rebe_pkg::REG_LONG_PRESS: prdata = {16'd0, r_long_press};
            default:                  prdata = '0;
        endcase
    end

    // The accumulator never holds a full detent between items.
    a_accum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.step_accum < $signed(4'(rebe_pkg::DETENT_STEPS))) &&
        (r_state.step_accum > -$signed(4'(rebe_pkg::DETENT_STEPS))))
        else $error("step accumulator reached a detent without an event");

    // A press in progress always matches a pressed debounced level.
    a_held_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.held == !r_state.button_stable)
        else $error("held flag disagrees with debounced level");

    // A long press result always leaves the hold marked as done.
    a_long_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_code == rebe_pkg::EV_LONG)) |-> r_state.long_done)
        else $error("long press reported without long_done set");

    // A result is produced for every advance of the input stage.
    a_advance_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advanced item produced no result");

endmodule
